// File: hw/rtl/crc8_escape_packet_framer_macros.svh
// Assertion helpers shared by the framer modules.
// Each macro expects clk and rst_n in the enclosing scope.
`ifndef CRC8_ESCAPE_PACKET_FRAMER_MACROS_SVH
`define CRC8_ESCAPE_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication.
`define CEF_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CEF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant that holds at every edge out of reset.
`define CEF_ASSERT_ALWAYS(label, cond, msg) \
  `CEF_ASSERT(label, 1'b1, cond, msg)

`endif

// File: hw/rtl/cef_pkg.sv
package cef_pkg;

  // Register reset values and fixed constants
  localparam logic [7:0] RST_MAX_PACKET = 8'd64;
  localparam logic [7:0] RST_DELIM      = 8'd254;
  localparam logic [7:0] RST_ESC        = 8'd253;
  localparam logic [7:0] CAP_MIN        = 8'd64;
  localparam logic [7:0] ESC_FLIP       = 8'h20;
  localparam logic [7:0] CRC_POLY       = 8'h8C;
  localparam logic [8:0] CLOSE_MARGIN   = 9'd4;
  localparam logic [8:0] FILL_SAT       = 9'd511;
  localparam logic [8:0] FILL_MAX_BODY  = 9'd256;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Output slots of one command, in emission order
  localparam int NUM_SLOTS     = 9;
  localparam int SLOT_PRE_ESC  = 0;
  localparam int SLOT_PRE_CRC  = 1;
  localparam int SLOT_PRE_END  = 2;
  localparam int SLOT_OPEN     = 3;
  localparam int SLOT_DAT_ESC  = 4;
  localparam int SLOT_DAT      = 5;
  localparam int SLOT_POST_ESC = 6;
  localparam int SLOT_POST_CRC = 7;
  localparam int SLOT_POST_END = 8;

  typedef enum logic [1:0] {
    REG_MAX_PACKET = 2'd0,
    REG_DELIM      = 2'd1,
    REG_ESC        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } cef_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       last;
  } cef_out_t;

  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] esc;
  } cef_cfg_t;

  // One classified request: optional close, optional open, optional body byte, optional close
  typedef struct packed {
    logic       pre_close;
    logic [7:0] pre_crc;
    logic       open;
    logic       body;
    logic [7:0] data;
    logic       post_close;
    logic [7:0] post_crc;
  } cef_cmd_t;

  // CRC-8 Maxim, reflected, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/cef_front.sv
module cef_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cef_pkg::cef_in_t   in_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  output cef_pkg::cef_cfg_t  cfg,
  output logic               q_push,
  output cef_pkg::cef_cmd_t  q_cmd,
  input  logic               q_full
);
  import cef_pkg::*;

  `include "crc8_escape_packet_framer_macros.svh"

  logic [7:0] cap_r, cap_nxt;
  logic [7:0] delim_r, delim_nxt;
  logic [7:0] esc_r, esc_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [8:0] fill_r, fill_nxt;
  logic [7:0] mbl_r, mbl_nxt;

  logic       accept, is_flush, msg_start, over_cap, pre_close, post_close;
  logic [7:0] b, crc0, crc1, mbl1;
  logic [8:0] fill0, fill1;
  logic [9:0] need;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign is_flush  = in_data.kind;
  assign b         = in_data.data_byte;
  assign msg_start = (mbl_r == 8'd0);

  // length byte + its body, against what is left in the open packet
  assign need      = {2'b00, b} + 10'd1 + {1'b0, fill_r};
  assign over_cap  = need > {2'b00, cap_r};
  assign pre_close = is_flush ? (fill_r != 9'd0) : (msg_start && over_cap && (fill_r != 9'd0));

  assign fill0 = pre_close ? 9'd0 : fill_r;
  assign crc0  = pre_close ? 8'd0 : crc_r;
  assign crc1  = crc8_update(crc0, b);
  assign fill1 = (fill0 == FILL_SAT) ? fill0 : fill0 + 9'd1;
  assign mbl1  = msg_start ? b : mbl_r - 8'd1;

  assign post_close = !is_flush && (mbl1 == 8'd0) &&
                      (fill1 > ({1'b0, cap_r} - CLOSE_MARGIN));

  always_comb begin
    q_cmd.pre_close  = pre_close;
    q_cmd.pre_crc    = crc_r;
    q_cmd.open       = !is_flush && (fill0 == 9'd0);
    q_cmd.body       = !is_flush;
    q_cmd.data       = b;
    q_cmd.post_close = post_close;
    q_cmd.post_crc   = crc1;
  end

  // a flush with nothing open produces no output at all
  assign q_push = accept && (!is_flush || (fill_r != 9'd0));

  assign cfg.delim = delim_r;
  assign cfg.esc   = esc_r;

  always_comb begin
    cap_nxt   = cap_r;
    delim_nxt = delim_r;
    esc_nxt   = esc_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MAX_PACKET: cap_nxt   = (cfg_wdata < CAP_MIN) ? CAP_MIN : cfg_wdata;
        REG_DELIM:      delim_nxt = cfg_wdata;
        REG_ESC:        esc_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    crc_nxt  = crc_r;
    fill_nxt = fill_r;
    mbl_nxt  = mbl_r;
    if (accept) begin
      if (is_flush) begin
        crc_nxt  = 8'd0;
        fill_nxt = 9'd0;
      end else begin
        crc_nxt  = post_close ? 8'd0 : crc1;
        fill_nxt = post_close ? 9'd0 : fill1;
        mbl_nxt  = mbl1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= RST_MAX_PACKET;
      delim_r <= RST_DELIM;
      esc_r   <= RST_ESC;
      crc_r   <= 8'd0;
      fill_r  <= 9'd0;
      mbl_r   <= 8'd0;
    end else begin
      cap_r   <= cap_nxt;
      delim_r <= delim_nxt;
      esc_r   <= esc_nxt;
      crc_r   <= crc_nxt;
      fill_r  <= fill_nxt;
      mbl_r   <= mbl_nxt;
    end
  end

  `CEF_ASSERT_NXT(a_flush_empties, accept && is_flush, fill_r == 9'd0, "flush left packet open")
  `CEF_ASSERT(a_cmd_nonempty, q_push, q_cmd.pre_close || q_cmd.body, "empty command pushed")
  `CEF_ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_MAX_BODY, "packet fill beyond one message")

endmodule

// File: hw/rtl/cef_fifo.sv
module cef_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cef_pkg::cef_cmd_t  push_cmd,
  output logic               full,
  output logic               head_valid,
  output cef_pkg::cef_cmd_t  head_cmd,
  input  logic               pop
);
  import cef_pkg::*;

  `include "crc8_escape_packet_framer_macros.svh"

  cef_cmd_t              entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]   count_r, count_nxt;

  localparam logic [QUEUE_AW-1:0] PTR_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CW-1:0] CNT_FULL = QUEUE_CW'(QUEUE_DEPTH);

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `CEF_ASSERT(a_no_overflow, push, !full, "push into full queue")
  `CEF_ASSERT(a_no_underflow, pop, head_valid, "pop from empty queue")
  `CEF_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_FULL, "queue count out of range")

endmodule

// File: hw/rtl/cef_back.sv
module cef_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cef_pkg::cef_cfg_t  cfg,
  input  logic               q_valid,
  input  cef_pkg::cef_cmd_t  q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output cef_pkg::cef_out_t  out_data
);
  import cef_pkg::*;

  `include "crc8_escape_packet_framer_macros.svh"

  logic [NUM_SLOTS-1:0] done_r, done_nxt;
  logic                 out_valid_r, out_valid_nxt;
  cef_out_t             out_data_r, out_data_nxt;

  logic [NUM_SLOTS-1:0] mask, rem, cur, slot_end;
  logic [7:0]           slot_byte [NUM_SLOTS];
  logic                 pre_esc, dat_esc, post_esc, is_last, advance, emit;
  logic [7:0]           sel_byte;
  logic                 sel_end;

  function automatic logic needs_esc(input logic [7:0] x, input cef_cfg_t c);
    return (x == c.delim) || (x == c.esc);
  endfunction

  assign pre_esc  = needs_esc(q_cmd.pre_crc, cfg);
  assign dat_esc  = needs_esc(q_cmd.data, cfg);
  assign post_esc = needs_esc(q_cmd.post_crc, cfg);

  always_comb begin
    mask = '0;
    mask[SLOT_PRE_ESC]  = q_cmd.pre_close && pre_esc;
    mask[SLOT_PRE_CRC]  = q_cmd.pre_close;
    mask[SLOT_PRE_END]  = q_cmd.pre_close;
    mask[SLOT_OPEN]     = q_cmd.open;
    mask[SLOT_DAT_ESC]  = q_cmd.body && dat_esc;
    mask[SLOT_DAT]      = q_cmd.body;
    mask[SLOT_POST_ESC] = q_cmd.post_close && post_esc;
    mask[SLOT_POST_CRC] = q_cmd.post_close;
    mask[SLOT_POST_END] = q_cmd.post_close;

    slot_byte[SLOT_PRE_ESC]  = cfg.esc;
    slot_byte[SLOT_PRE_CRC]  = pre_esc ? (q_cmd.pre_crc ^ ESC_FLIP) : q_cmd.pre_crc;
    slot_byte[SLOT_PRE_END]  = cfg.delim;
    slot_byte[SLOT_OPEN]     = cfg.delim;
    slot_byte[SLOT_DAT_ESC]  = cfg.esc;
    slot_byte[SLOT_DAT]      = dat_esc ? (q_cmd.data ^ ESC_FLIP) : q_cmd.data;
    slot_byte[SLOT_POST_ESC] = cfg.esc;
    slot_byte[SLOT_POST_CRC] = post_esc ? (q_cmd.post_crc ^ ESC_FLIP) : q_cmd.post_crc;
    slot_byte[SLOT_POST_END] = cfg.delim;

    slot_end = '0;
    slot_end[SLOT_PRE_END]  = 1'b1;
    slot_end[SLOT_POST_END] = 1'b1;
  end

  // lowest pending slot goes out next
  assign rem     = mask & ~done_r;
  assign cur     = rem & (~rem + 1'b1);
  assign is_last = ((rem & ~cur) == '0);

  always_comb begin
    sel_byte = '0;
    sel_end  = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sel_byte = sel_byte | (cur[i] ? slot_byte[i] : 8'd0);
      sel_end  = sel_end | (cur[i] & slot_end[i]);
    end
  end

  assign advance = !out_valid_r || !out_stall;
  assign emit    = advance && q_valid;
  assign q_pop   = emit && is_last;

  always_comb begin
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.out_byte   = sel_byte;
      out_data_nxt.packet_end = sel_end;
      out_data_nxt.last       = is_last;
      done_nxt                = is_last ? '0 : (done_r | cur);
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CEF_ASSERT(a_done_subset, q_valid, (done_r & ~mask) == '0, "done slot outside command")
  `CEF_ASSERT(a_idle_clean, !q_valid, done_r == '0, "stale progress without command")
  `CEF_ASSERT(a_end_is_delim, out_valid && out_data.packet_end,
              out_data.out_byte == cfg.delim, "packet end is not a delimiter")
  `CEF_ASSERT(a_cmd_has_work, q_valid, rem != '0, "queued command with nothing to send")

endmodule

// File: hw/rtl/crc8_escape_packet_framer.sv
// Byte-stuffing packet framer with CRC-8 (Maxim) trailer.
// Input channel (in_valid / in_stall / in_data): one request per byte, kind 0 is a message
//   byte (first byte of each message is its remaining length), kind 1 is a flush request.
// Output channel (out_valid / out_stall / out_data): the framed serial stream;
//   packet_end marks a closing delimiter, last marks the final byte caused by an input.
// Config port (cfg_we / cfg_index / cfg_wdata): 0 max packet bytes (clamped to >= 64),
//   1 frame delimiter, 2 escape code. Write only while the block is idle.
// Path: an accepted input is first registered in the command queue, and its output bytes
//   then leave through the output register, so none appears in the cycle of acceptance.
// Throughput: the output side sends one byte per cycle while out_stall is low; an input
//   produces 0 to 6 bytes (none for a flush with no open packet, typically 1, 2 with
//   an escape, more when a packet opens or closes). The front classifies one input per
//   cycle into a 2-entry command queue, so input acceptance stalls only when that queue
//   is full.
// Reset (synchronous, rst_n low) empties the queue and output register, clears CRC, fill and
//   message count, and loads register defaults 64 / 0xFE / 0xFD.
// When out_stall is high the output byte holds; the queue then fills and in_stall rises.
module crc8_escape_packet_framer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cef_pkg::cef_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cef_pkg::cef_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);
  import cef_pkg::*;

  cef_cfg_t cfg;
  logic     q_push, q_full, q_valid, q_pop;
  cef_cmd_t q_in_cmd, q_head_cmd;

  // front: config registers, packet state, classification of each request
  cef_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd),
    .q_full    (q_full)
  );

  // short command queue decoupling classification from byte emission
  cef_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop)
  );

  // back: expands each command into escaped bytes, one per cycle unless out_stall holds them, into the output register
  cef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
